// ===== design/pidsi_pkg.sv =====
// Package for the PID step block: payload structs, state encoding and
// fixed-point helpers. Used by every design file but pidsi_div; depends on nothing.
package pidsi_pkg;

    typedef struct packed {
        logic signed [31:0] target_value;
        logic signed [31:0] measured_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               settled;
        logic               active;
    } t_out;

    localparam int unsigned CFG_PROP_GAIN    = 0;
    localparam int unsigned CFG_INTEG_GAIN   = 1;
    localparam int unsigned CFG_DERIV_GAIN   = 2;
    localparam int unsigned CFG_DEAD_BAND    = 3;
    localparam int unsigned CFG_OPTION_BITS  = 4;
    localparam int unsigned CFG_LIMITS       = 5;
    localparam int unsigned CFG_RATE_BANDS   = 6;
    localparam int unsigned CFG_FILTER_COEFS = 7;

    localparam logic [31:0] LIMITS_RST     = 32'h7FFF_7FFF;
    localparam logic [31:0] RATE_BANDS_RST = 32'h0032_0032;
    localparam logic [32:0] SETTLE_BAND    = 33'd2000;

    // option bit positions
    localparam int unsigned OPT_TRAP   = 0;
    localparam int unsigned OPT_VRATE  = 1;
    localparam int unsigned OPT_ICLAMP = 2;
    localparam int unsigned OPT_DMEAS  = 3;
    localparam int unsigned OPT_DFILT  = 4;
    localparam int unsigned OPT_OFILT  = 5;

    localparam int unsigned MUL_A_W = 35;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_CHK  = 24'h000002,
        S_MP   = 24'h000004,
        S_MI   = 24'h000008,
        S_MD   = 24'h000010,
        S_MM   = 24'h000020,
        S_RATE = 24'h000040,
        S_VL   = 24'h000080,
        S_VH   = 24'h000100,
        S_VC   = 24'h000200,
        S_VW   = 24'h000400,
        S_CL1  = 24'h000800,
        S_CL2  = 24'h001000,
        S_INT  = 24'h002000,
        S_B0   = 24'h004000,
        S_B1   = 24'h008000,
        S_B2   = 24'h010000,
        S_B3   = 24'h020000,
        S_B4   = 24'h040000,
        S_B5   = 24'h080000,
        S_Y1   = 24'h100000,
        S_Y2   = 24'h200000,
        S_SAT  = 24'h400000,
        S_OUT  = 24'h800000
    } t_state;

    // saturate a wide signed value to the 48-bit Q32.16 range
    function automatic logic signed [47:0] sat48(input logic signed [67:0] v);
        logic signed [47:0] r;
        if (v[67:47] == {21{1'b0}} || v[67:47] == {21{1'b1}}) begin
            r = v[47:0];
        end else if (v[67]) begin
            r = {1'b1, 47'b0};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic same_sign(input logic signed [32:0] e,
                                       input logic signed [47:0] x);
        logic r;
        r = ((!e[32] && e != '0) && (!x[47] && x != '0)) || (e[32] && x[47]);
        return r;
    endfunction

endpackage

// ===== design/pid_step_with_integral_options.sv =====
// PID step with integral options: sequencer, state and output register.
// Depends on pidsi_pkg, pidsi_mul and pidsi_div.
//
//  channel   direction  handshake                 payload
//  in        in         i_in_valid / o_in_ready   i_in_data  (t_in)
//  out       out        o_out_valid / i_out_ready o_out_data (t_out)
//  cfg       in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// An item inside the deadband goes from the check to the output step; an
// active item adds the multiply, integral and sum steps, a filter pass per
// enabled filter, and the one-bit-per-cycle divider when the integral rate ramps.
// All products go through the one 35x32 multiplier, one per cycle.
// Reset is synchronous and active low; it resets state and configuration.
// A stalled output holds the sequencer in its last step; the next item is
// taken once the result moves to the output register.
module pid_step_with_integral_options (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pidsi_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pidsi_pkg::t_out   o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    pidsi_pkg::t_state r_state, n_state;

    logic signed [31:0] r_kp, r_ki, r_kd;
    logic [15:0] r_db;
    logic [5:0]  r_opt;
    logic [31:0] r_lim, r_rb, r_fc;

    logic signed [32:0] r_e, n_e;
    logic signed [31:0] r_meas, n_meas;
    logic [32:0] r_ae, n_ae;
    logic        r_act, n_act;
    logic signed [47:0] r_p, n_p, r_i, n_i, r_d0, n_d0, r_dm, n_dm, r_d, n_d;
    logic signed [47:0] r_y, n_y, r_t, n_t, r_ti, n_ti;
    logic signed [47:0] r_integ, n_integ, r_dterm, n_dterm, r_held, n_held;
    logic signed [32:0] r_pe, n_pe;
    logic signed [31:0] r_pm, n_pm;
    logic signed [55:0] r_acc, n_acc;
    logic        r_bsel, n_bsel;
    logic signed [47:0] r_ba, n_ba, r_bb, n_bb;
    logic [15:0] r_bc, n_bc;
    logic        r_ovalid, n_ovalid;
    pidsi_pkg::t_out r_out, n_out;

    logic signed [pidsi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pidsi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pidsi_pkg::PROD_W-1:0]  prod;
    logic        div_start, div_done;
    logic [63:0] div_dvd;
    logic [47:0] div_q;

    // derived configuration
    logic [14:0] ol, il;
    logic signed [47:0] olq, ilq;
    logic [15:0] ra, rb, cd, co;
    logic [16:0] rab;
    logic [15:0] rf;
    logic [47:0] imag;
    logic signed [17:0] bd;
    logic [32:0] ae_c;
    logic signed [47:0] prod_s, t_c, y_c, dv_c, res_c;
    logic ss;

    assign ol  = (r_lim[15:0] > 16'd32767) ? 15'h7FFF : r_lim[14:0];
    assign il  = (r_lim[31:16] > 16'd32767) ? 15'h7FFF : r_lim[30:16];
    assign olq = {17'b0, ol, 16'b0};
    assign ilq = {17'b0, il, 16'b0};
    assign ra  = r_rb[15:0];
    assign rb  = r_rb[31:16];
    assign cd  = r_fc[15:0];
    assign co  = r_fc[31:16];
    assign rab = {1'b0, ra} + {1'b0, rb};
    assign rf  = 16'(rab - r_ae[16:0]);
    assign imag = r_i[47] ? 48'(-r_i) : 48'(r_i);
    assign bd  = 18'sd32768 - $signed({2'b0, r_bc});
    assign ae_c = r_e[32] ? 33'(-r_e) : 33'(r_e);
    assign prod_s = pidsi_pkg::sat48(68'(prod));
    assign ss = pidsi_pkg::same_sign(r_e, r_integ);
    assign t_c = pidsi_pkg::sat48(68'(r_t) + 68'(r_d0));
    assign y_c = pidsi_pkg::sat48(68'(r_y) + 68'(r_d));
    assign dv_c = r_opt[pidsi_pkg::OPT_DMEAS] ? r_dm : r_d0;
    assign res_c = pidsi_pkg::sat48(68'(r_acc));
    assign div_dvd = 64'(r_acc) + {prod[39:0], 24'b0};
    assign div_start = (r_state == pidsi_pkg::S_VC);

    pidsi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pidsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (ra),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            pidsi_pkg::S_MP: begin
                mul_a = 35'(r_e);
                mul_b = r_kp;
            end
            pidsi_pkg::S_MI: begin
                mul_a = r_opt[pidsi_pkg::OPT_TRAP] ? 35'(35'(r_e) + 35'(r_pe)) : 35'(r_e);
                mul_b = r_ki;
            end
            pidsi_pkg::S_MD: begin
                mul_a = 35'(35'(r_e) - 35'(r_pe));
                mul_b = r_kd;
            end
            pidsi_pkg::S_MM: begin
                mul_a = 35'(35'(r_pm) - 35'(r_meas));
                mul_b = r_kd;
            end
            pidsi_pkg::S_VL: begin
                mul_a = {11'b0, imag[23:0]};
                mul_b = {16'b0, rf};
            end
            pidsi_pkg::S_VH: begin
                mul_a = {11'b0, imag[47:24]};
                mul_b = {16'b0, rf};
            end
            pidsi_pkg::S_B0: begin
                mul_a = {20'b0, r_ba[14:0]};
                mul_b = {16'b0, r_bc};
            end
            pidsi_pkg::S_B1: begin
                mul_a = {20'b0, r_bb[14:0]};
                mul_b = 32'(bd);
            end
            pidsi_pkg::S_B2: begin
                mul_a = 35'($signed(r_ba[47:15]));
                mul_b = {16'b0, r_bc};
            end
            pidsi_pkg::S_B3: begin
                mul_a = 35'($signed(r_bb[47:15]));
                mul_b = 32'(bd);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_e = r_e; n_meas = r_meas; n_ae = r_ae; n_act = r_act;
        n_p = r_p; n_i = r_i; n_d0 = r_d0; n_dm = r_dm; n_d = r_d;
        n_y = r_y; n_t = r_t; n_ti = r_ti;
        n_integ = r_integ; n_dterm = r_dterm; n_held = r_held;
        n_pe = r_pe; n_pm = r_pm; n_acc = r_acc;
        n_bsel = r_bsel; n_ba = r_ba; n_bb = r_bb; n_bc = r_bc;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out = r_out;
        case (r_state)
            pidsi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_e = 33'(i_in_data.target_value) - 33'(i_in_data.measured_value);
                    n_meas = i_in_data.measured_value;
                    n_state = pidsi_pkg::S_CHK;
                end
            end
            pidsi_pkg::S_CHK: begin
                n_ae = ae_c;
                n_act = ae_c > {17'b0, r_db};
                n_state = (ae_c > {17'b0, r_db}) ? pidsi_pkg::S_MP : pidsi_pkg::S_OUT;
            end
            pidsi_pkg::S_MP: n_state = pidsi_pkg::S_MI;
            pidsi_pkg::S_MI: begin
                n_p = prod_s;
                n_state = pidsi_pkg::S_MD;
            end
            pidsi_pkg::S_MD: begin
                n_i = r_opt[pidsi_pkg::OPT_TRAP] ? pidsi_pkg::sat48(68'(prod >>> 1)) : prod_s;
                n_state = pidsi_pkg::S_MM;
            end
            pidsi_pkg::S_MM: begin
                n_d0 = prod_s;
                n_state = pidsi_pkg::S_RATE;
            end
            pidsi_pkg::S_RATE: begin
                n_dm = prod_s;
                n_state = r_opt[pidsi_pkg::OPT_ICLAMP] ? pidsi_pkg::S_CL1 : pidsi_pkg::S_INT;
                if (r_opt[pidsi_pkg::OPT_VRATE] && ss && r_ae > {17'b0, rb}) begin
                    if (r_ae <= {16'b0, rab}) begin
                        n_state = pidsi_pkg::S_VL;
                    end else begin
                        n_i = '0;
                    end
                end
            end
            pidsi_pkg::S_VL: n_state = pidsi_pkg::S_VH;
            pidsi_pkg::S_VH: begin
                n_acc = 56'(prod[39:0]);
                n_state = pidsi_pkg::S_VC;
            end
            pidsi_pkg::S_VC: n_state = pidsi_pkg::S_VW;
            pidsi_pkg::S_VW: begin
                if (div_done) begin
                    // quotient magnitude takes the sign of the integral step
                    n_i = r_i[47] ? -$signed(div_q) : $signed(div_q);
                    n_state = r_opt[pidsi_pkg::OPT_ICLAMP] ? pidsi_pkg::S_CL1
                                                           : pidsi_pkg::S_INT;
                end
            end
            pidsi_pkg::S_CL1: begin
                n_t = pidsi_pkg::sat48(68'(r_p) + 68'(r_integ));
                n_ti = pidsi_pkg::sat48(68'(r_integ) + 68'(r_i));
                n_state = pidsi_pkg::S_CL2;
            end
            pidsi_pkg::S_CL2: begin
                if ((t_c > olq || t_c < -olq) && ss) begin
                    n_i = '0;
                end
                if (r_ti > ilq) begin
                    n_i = '0;
                    n_integ = ilq;
                end
                if (r_ti < -ilq) begin
                    n_i = '0;
                    n_integ = -ilq;
                end
                n_state = pidsi_pkg::S_INT;
            end
            pidsi_pkg::S_INT: begin
                n_integ = pidsi_pkg::sat48(68'(r_integ) + 68'(r_i));
                n_d = dv_c;
                if (r_opt[pidsi_pkg::OPT_DFILT]) begin
                    n_ba = dv_c;
                    n_bb = r_dterm;
                    n_bc = cd;
                    n_bsel = 1'b0;
                    n_state = pidsi_pkg::S_B0;
                end else begin
                    n_state = pidsi_pkg::S_Y1;
                end
            end
            pidsi_pkg::S_B0: n_state = pidsi_pkg::S_B1;
            pidsi_pkg::S_B1: begin
                n_acc = 56'(prod);
                n_state = pidsi_pkg::S_B2;
            end
            pidsi_pkg::S_B2: begin
                n_acc = r_acc + 56'(prod);
                n_state = pidsi_pkg::S_B3;
            end
            pidsi_pkg::S_B3: begin
                // floor the low-part sum, then add the high-part products
                n_acc = (r_acc >>> 15) + 56'(prod);
                n_state = pidsi_pkg::S_B4;
            end
            pidsi_pkg::S_B4: begin
                n_acc = r_acc + 56'(prod);
                n_state = pidsi_pkg::S_B5;
            end
            pidsi_pkg::S_B5: begin
                if (r_bsel) begin
                    n_y = res_c;
                    n_state = pidsi_pkg::S_SAT;
                end else begin
                    n_d = res_c;
                    n_state = pidsi_pkg::S_Y1;
                end
            end
            pidsi_pkg::S_Y1: begin
                n_y = pidsi_pkg::sat48(68'(r_p) + 68'(r_integ));
                n_state = pidsi_pkg::S_Y2;
            end
            pidsi_pkg::S_Y2: begin
                n_y = y_c;
                if (r_opt[pidsi_pkg::OPT_OFILT]) begin
                    n_ba = y_c;
                    n_bb = r_held;
                    n_bc = co;
                    n_bsel = 1'b1;
                    n_state = pidsi_pkg::S_B0;
                end else begin
                    n_state = pidsi_pkg::S_SAT;
                end
            end
            pidsi_pkg::S_SAT: begin
                if (r_y > olq) begin
                    n_held = olq;
                end else if (r_y < -olq) begin
                    n_held = -olq;
                end else begin
                    n_held = r_y;
                end
                n_dterm = r_d;
                n_state = pidsi_pkg::S_OUT;
            end
            pidsi_pkg::S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    // truncate toward zero to the integer part
                    n_out.drive = 16'(r_held[32:16] +
                        17'(r_held[47] && r_held[15:0] != '0));
                    n_out.settled = r_ae < pidsi_pkg::SETTLE_BAND;
                    n_out.active = r_act;
                    n_pe = r_e;
                    n_pm = r_meas;
                    n_state = pidsi_pkg::S_IDLE;
                end
            end
            default: n_state = pidsi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pidsi_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_integ  <= '0;
            r_dterm  <= '0;
            r_held   <= '0;
            r_pe     <= '0;
            r_pm     <= '0;
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_db     <= '0;
            r_opt    <= '0;
            r_lim    <= pidsi_pkg::LIMITS_RST;
            r_rb     <= pidsi_pkg::RATE_BANDS_RST;
            r_fc     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_integ  <= n_integ;
            r_dterm  <= n_dterm;
            r_held   <= n_held;
            r_pe     <= n_pe;
            r_pm     <= n_pm;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    3'(pidsi_pkg::CFG_PROP_GAIN):    r_kp  <= i_cfg_data;
                    3'(pidsi_pkg::CFG_INTEG_GAIN):   r_ki  <= i_cfg_data;
                    3'(pidsi_pkg::CFG_DERIV_GAIN):   r_kd  <= i_cfg_data;
                    3'(pidsi_pkg::CFG_DEAD_BAND):    r_db  <= i_cfg_data[15:0];
                    3'(pidsi_pkg::CFG_OPTION_BITS):  r_opt <= i_cfg_data[5:0];
                    3'(pidsi_pkg::CFG_LIMITS):       r_lim <= i_cfg_data;
                    3'(pidsi_pkg::CFG_RATE_BANDS):   r_rb  <= i_cfg_data;
                    3'(pidsi_pkg::CFG_FILTER_COEFS): r_fc  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_meas <= n_meas;
        r_ae   <= n_ae;
        r_act  <= n_act;
        r_p    <= n_p;
        r_i    <= n_i;
        r_d0   <= n_d0;
        r_dm   <= n_dm;
        r_d    <= n_d;
        r_y    <= n_y;
        r_t    <= n_t;
        r_ti   <= n_ti;
        r_acc  <= n_acc;
        r_bsel <= n_bsel;
        r_ba   <= n_ba;
        r_bb   <= n_bb;
        r_bc   <= n_bc;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == pidsi_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

// ===== design/pidsi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pidsi_pkg for operand widths.
module pidsi_mul (
    input  logic                                   i_clk,
    input  logic signed [pidsi_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [pidsi_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [pidsi_pkg::PROD_W-1:0]    o_prod
);
    logic signed [pidsi_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= pidsi_pkg::PROD_W'(i_a) * pidsi_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule

// ===== design/pidsi_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 16-bit
// divisor, quotient known to fit 48 bits. No package dependency.
module pidsi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [15:0] r_rem;
    logic [47:0] r_lo;
    logic [15:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic [16:0] diff;

    assign trial = {r_rem, r_lo[47]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:48];
            r_lo  <= i_dividend[47:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, keep the difference if it fits
            if (!diff[16]) begin
                r_rem <= diff[15:0];
                r_lo  <= {r_lo[46:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_lo  <= {r_lo[46:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;
endmodule

// ===== design/pidsi_chk.sv =====
// Port-level checker for the PID step block, bound to the top level.
// Depends on pidsi_pkg for the payload structs.
module pidsi_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input pidsi_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input pidsi_pkg::t_out o_out_data,
    input logic            i_cfg_wr_en,
    input logic [2:0]      i_cfg_index,
    input logic [31:0]     i_cfg_data
);
    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed before transfer");

    // after an input transfer the block is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // a new result only appears at the end of a step
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without a step");

    // drive never reaches the most negative code
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.drive != 16'sh8000)
        else $error("drive out of range");

    logic unused_ok;
    assign unused_ok = ^{i_in_data, i_cfg_wr_en, i_cfg_index, i_cfg_data};
endmodule

bind pid_step_with_integral_options pidsi_chk u_pidsi_chk (.*);
